FILE: rtl/core/phd_pkg.sv
// ----------------------------------------------------------------------------
// phd_pkg
// Shared types and constants for the per-bin peak hold and decay core.
// ----------------------------------------------------------------------------
package phd_pkg;

    localparam int BIN_W  = 7;
    localparam int MAG_W  = 7;
    localparam int CNT_W  = 16;
    localparam int AMT_W  = 8;
    localparam int LVL_W  = 8;
    localparam int CFG_W  = 16;
    localparam int CFGI_W = 2;

    localparam int BIN_SPAN = 1 << BIN_W;

    localparam logic [MAG_W-1:0] PEAK_MAX = 7'd127;
    localparam logic [CNT_W-1:0] CNT_MAX  = 16'hFFFF;

    typedef enum logic [CFGI_W-1:0] {
        CFG_HOLD,
        CFG_INTERVAL,
        CFG_AMOUNT
    } t_cfg_idx;

    typedef struct packed {
        logic [BIN_W-1:0] bin_index;
        logic [MAG_W-1:0] rssi_magnitude;
    } t_in_word;

    typedef struct packed {
        logic [BIN_W-1:0]        bin_out;
        logic [MAG_W-1:0]        peak_magnitude;
        logic signed [LVL_W-1:0] level_dbm;
    } t_out_word;

    typedef struct packed {
        logic [MAG_W-1:0] peak;
        logic [CNT_W-1:0] cnt;
    } t_entry;

    // per-word context carried down the pipeline
    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic [MAG_W-1:0] mag;
        logic             inr;
        logic             le;
        logic             try_decay;
        logic [MAG_W-1:0] peak;
        logic [CNT_W-1:0] cnt;
    } t_ctx;

endpackage

FILE: rtl/core/phd_store.sv
// ----------------------------------------------------------------------------
// phd_store
// Per-bin peak and hold counter memory, one read and one write port, with
// registered read data and per-entry valid bits standing in for reset values.
// ----------------------------------------------------------------------------
module phd_store import phd_pkg::*; #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_entry,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_entry
);

    t_entry           r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    t_entry           r_q;
    logic             r_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_q_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_entry = r_q_vld ? r_q : t_entry'{peak: PEAK_MAX, cnt: '0};

endmodule

FILE: rtl/core/phd_mod_pipe.sv
// ----------------------------------------------------------------------------
// phd_mod_pipe
// Restoring remainder pipeline, one quotient bit per stage, carrying the
// word context alongside. Reports whether a given bin is in flight.
// ----------------------------------------------------------------------------
module phd_mod_pipe import phd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    output logic             o_rdy,
    input  t_ctx             i_ctx,
    input  logic [CNT_W-1:0] i_phase,
    input  logic [CNT_W-1:0] i_div,
    input  logic [BIN_W-1:0] i_probe_bin,
    output logic             o_hit,
    output logic             o_vld,
    input  logic             i_rdy,
    output t_ctx             o_ctx,
    output logic [CNT_W-1:0] o_rem
);

    localparam int NSTG = CNT_W;

    logic             r_vld [NSTG];
    t_ctx             r_ctx [NSTG];
    logic [CNT_W-1:0] r_rem [NSTG];
    logic [CNT_W-1:0] r_ph  [NSTG];

    logic             s_vld [NSTG];
    t_ctx             s_ctx [NSTG];
    logic [CNT_W-1:0] s_rem [NSTG];
    logic [CNT_W-1:0] s_ph  [NSTG];
    logic             w_rdy [NSTG];
    logic             w_nrdy[NSTG];
    logic [CNT_W-1:0] n_rem [NSTG];

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        logic [CNT_W:0] w_t;
        logic [CNT_W:0] w_d;

        if (k == 0) begin : g_head
            assign s_vld[k] = i_vld;
            assign s_ctx[k] = i_ctx;
            assign s_rem[k] = '0;
            assign s_ph[k]  = i_phase;
        end else begin : g_body
            assign s_vld[k] = r_vld[k-1];
            assign s_ctx[k] = r_ctx[k-1];
            assign s_rem[k] = r_rem[k-1];
            assign s_ph[k]  = r_ph[k-1];
        end

        if (k == NSTG - 1) begin : g_tail
            assign w_nrdy[k] = i_rdy;
        end else begin : g_mid
            assign w_nrdy[k] = w_rdy[k+1];
        end

        assign w_rdy[k] = !r_vld[k] || w_nrdy[k];

        assign w_t      = {s_rem[k], s_ph[k][CNT_W-1]};
        assign w_d      = w_t - {1'b0, i_div};
        assign n_rem[k] = (w_t >= {1'b0, i_div}) ? w_d[CNT_W-1:0] : w_t[CNT_W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_vld[k] <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k] && s_vld[k]) begin
                r_ctx[k] <= s_ctx[k];
                r_rem[k] <= n_rem[k];
                r_ph[k]  <= {s_ph[k][CNT_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        o_hit = 1'b0;
        for (int k = 0; k < NSTG; k++) begin
            o_hit = o_hit | (r_vld[k] && (r_ctx[k].bin == i_probe_bin));
        end
    end

    assign o_rdy = w_rdy[0];
    assign o_vld = r_vld[NSTG-1];
    assign o_ctx = r_ctx[NSTG-1];
    assign o_rem = r_rem[NSTG-1];

endmodule

FILE: rtl/core/per_bin_peak_hold_decay_core.sv
// ----------------------------------------------------------------------------
// per_bin_peak_hold_decay_core
// Per-bin peak hold with decay for a spectrum display.
// ----------------------------------------------------------------------------
// One input word per cycle is taken while no word in flight addresses the
// same bin and the output side does not hold the flow; every word yields
// one output word (memory read registered at the accepting edge, then counter
// update and decay phase, 16 remainder stages, output register). A word for
// a bin that is still in flight waits until the earlier word has written
// back its peak and counter, so repeats of one bin do not overlap in the
// pipeline. Peaks read as 127 and counters as 0 after reset with no clearing
// pass. Configuration registers may be written only when idle.
// ----------------------------------------------------------------------------
module per_bin_peak_hold_decay_core import phd_pkg::*; #(
    parameter int NUM_BINS = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_word         o_out_word,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFGI_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int DEPTH = (NUM_BINS < BIN_SPAN) ? NUM_BINS : BIN_SPAN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CNT_W-1:0] r_hold;
    logic [CNT_W-1:0] r_intv;
    logic [AMT_W-1:0] r_amt;

    logic             r_a_vld;
    logic [BIN_W-1:0] r_a_bin;
    logic [MAG_W-1:0] r_a_mag;
    logic             r_a_inr;

    logic             r_b_vld;
    t_ctx             r_b_ctx;

    logic             r_o_vld;
    t_out_word        r_o_word;

    logic             w_acc;
    logic             w_hit;
    logic             w_rdy_a;
    logic             w_rdy_b;
    logic             w_rdy_o;
    logic             w_inr;
    t_entry           w_rd;
    t_ctx             n_b_ctx;
    logic [CNT_W-1:0] w_cnt_inc;
    t_ctx             w_m_ctx;
    logic [CNT_W-1:0] w_phase;
    logic [CNT_W-1:0] w_div;
    logic             w_m_rdy;
    logic             w_m_hit;
    logic             w_q_vld;
    t_ctx             w_q_ctx;
    logic [CNT_W-1:0] w_q_rem;
    logic [AMT_W:0]   w_sum;
    logic [MAG_W-1:0] w_decayed;
    logic [MAG_W-1:0] n_peak;
    logic             w_wr_en;
    t_out_word        n_o_word;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= CNT_W'(2);
            r_intv <= CNT_W'(1);
            r_amt  <= AMT_W'(2);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HOLD:     r_hold <= i_cfg_data;
                CFG_INTERVAL: r_intv <= i_cfg_data;
                CFG_AMOUNT:   r_amt  <= i_cfg_data[AMT_W-1:0];
                default:      ;
            endcase
        end
    end

    // input side and in-flight interlock
    assign w_inr   = {{(32-BIN_W){1'b0}}, i_in_word.bin_index} < 32'(NUM_BINS);
    assign w_hit   = (r_a_vld && (r_a_bin == i_in_word.bin_index))
                  || (r_b_vld && (r_b_ctx.bin == i_in_word.bin_index))
                  || w_m_hit;
    assign w_rdy_o = !r_o_vld || i_out_ready;
    assign w_rdy_b = !r_b_vld || w_m_rdy;
    assign w_rdy_a = !r_a_vld || w_rdy_b;
    assign o_in_ready = w_rdy_a && !w_hit;
    assign w_acc   = i_in_valid && o_in_ready;

    phd_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_acc),
        .i_rd_addr  (i_in_word.bin_index[AW-1:0]),
        .o_rd_entry (w_rd),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_q_ctx.bin[AW-1:0]),
        .i_wr_entry (t_entry'{peak: n_peak, cnt: w_q_ctx.cnt})
    );

    // stage A: memory data arrives
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_rdy_a) begin
            r_a_vld <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_a_bin <= i_in_word.bin_index;
            r_a_mag <= i_in_word.rssi_magnitude;
            r_a_inr <= w_inr;
        end
    end

    assign w_cnt_inc = (w_rd.cnt == CNT_MAX) ? w_rd.cnt : w_rd.cnt + CNT_W'(1);

    always_comb begin
        n_b_ctx           = '0;
        n_b_ctx.bin       = r_a_bin;
        n_b_ctx.mag       = r_a_mag;
        n_b_ctx.inr       = r_a_inr;
        n_b_ctx.le        = r_a_mag <= w_rd.peak;
        n_b_ctx.peak      = w_rd.peak;
        n_b_ctx.cnt       = n_b_ctx.le ? '0 : w_cnt_inc;
        n_b_ctx.try_decay = 1'b0;
    end

    // stage B: decay phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_rdy_b) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_b && r_a_vld) begin
            r_b_ctx <= n_b_ctx;
        end
    end

    always_comb begin
        w_m_ctx           = r_b_ctx;
        w_m_ctx.try_decay = !r_b_ctx.le && (r_b_ctx.cnt > r_hold)
                         && (r_b_ctx.peak < PEAK_MAX);
    end

    assign w_phase = r_b_ctx.cnt - r_hold;
    assign w_div   = (r_intv == '0) ? CNT_W'(1) : r_intv;

    phd_mod_pipe u_mod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (r_b_vld),
        .o_rdy       (w_m_rdy),
        .i_ctx       (w_m_ctx),
        .i_phase     (w_phase),
        .i_div       (w_div),
        .i_probe_bin (i_in_word.bin_index),
        .o_hit       (w_m_hit),
        .o_vld       (w_q_vld),
        .i_rdy       (w_rdy_o),
        .o_ctx       (w_q_ctx),
        .o_rem       (w_q_rem)
    );

    // write-back and output register
    assign w_sum     = {2'b00, w_q_ctx.peak} + {1'b0, r_amt};
    assign w_decayed = (w_sum > {2'b00, PEAK_MAX}) ? PEAK_MAX : w_sum[MAG_W-1:0];

    always_comb begin
        if (w_q_ctx.le) begin
            n_peak = w_q_ctx.mag;
        end else if (w_q_ctx.try_decay && (w_q_rem == '0)) begin
            n_peak = w_decayed;
        end else begin
            n_peak = w_q_ctx.peak;
        end
    end

    assign w_wr_en = w_q_vld && w_rdy_o && w_q_ctx.inr;

    always_comb begin
        n_o_word.bin_out        = w_q_ctx.bin;
        n_o_word.peak_magnitude = w_q_ctx.inr ? n_peak : PEAK_MAX;
        n_o_word.level_dbm      = LVL_W'(0) - {1'b0, w_q_ctx.mag};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_rdy_o) begin
            r_o_vld <= w_q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_o && w_q_vld) begin
            r_o_word <= n_o_word;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_out_word  = r_o_word;

endmodule

FILE: tb/sv/tb_per_bin_peak_hold_decay_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_bin_peak_hold_decay_core
// Self-checking bench for the per-bin peak hold and decay core.
// Input words are queued by phase and sent with random gaps. Each accepted
// word is run through a local peak/counter model, and every output word is
// checked field by field against the oldest prediction. The phases cover a
// directed set of edge cases and random sweeps under changing register
// settings.
// ----------------------------------------------------------------------------
module tb_per_bin_peak_hold_decay_core;
    import phd_pkg::*;

    localparam int NUM_BINS    = 128;
    localparam int STALL_LIMIT = 2000;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_in_word          i_in_word   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_word         o_out_word;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFGI_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data  = '0;

    per_bin_peak_hold_decay_core #(
        .NUM_BINS(NUM_BINS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // local copy of the bin state and registers
    logic [MAG_W-1:0] peak_held  [NUM_BINS];
    logic [CNT_W-1:0] hold_count [NUM_BINS];
    logic [CNT_W-1:0] hold_len;
    logic [CNT_W-1:0] decay_ival;
    logic [AMT_W-1:0] decay_amt;

    t_in_word  sample_queue[$];
    t_out_word report_queue[$];

    logic calm;
    int   send_wait;
    int   recv_wait;
    int   stall_cycles;
    int   mismatches;
    int   samples_sent;
    int   reports_seen;
    int   reg_writes;

    function automatic int draw_gap();
        return calm ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic t_out_word predict_report(t_in_word w);
        int        pk;
        int        cnt;
        int        phase;
        int        iv;
        t_out_word r;
        r.bin_out        = w.bin_index;
        r.level_dbm      = -$signed({1'b0, w.rssi_magnitude});
        r.peak_magnitude = PEAK_MAX;
        if (int'(w.bin_index) < NUM_BINS) begin
            pk  = peak_held[w.bin_index];
            cnt = hold_count[w.bin_index];
            if (int'(w.rssi_magnitude) <= pk) begin
                pk  = w.rssi_magnitude;
                cnt = 0;
            end else begin
                if (cnt < int'(CNT_MAX)) cnt++;
                if (cnt > int'(hold_len)) begin
                    phase = cnt - int'(hold_len);
                    iv    = (decay_ival == '0) ? 1 : int'(decay_ival);
                    if ((phase % iv) == 0 && pk < int'(PEAK_MAX)) begin
                        pk = pk + int'(decay_amt);
                        if (pk > int'(PEAK_MAX)) pk = PEAK_MAX;
                    end
                end
            end
            peak_held[w.bin_index]  = MAG_W'(pk);
            hold_count[w.bin_index] = CNT_W'(cnt);
            r.peak_magnitude        = MAG_W'(pk);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : sample_driver
        logic busy;
        busy = i_in_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_wait  <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                report_queue.push_back(predict_report(i_in_word));
                samples_sent++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (send_wait > 0) begin
                    send_wait  <= send_wait - 1;
                    i_in_valid <= 1'b0;
                end else if (sample_queue.size() > 0) begin
                    i_in_word  <= sample_queue.pop_front();
                    i_in_valid <= 1'b1;
                    send_wait  <= draw_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : report_monitor
        t_out_word want;
        int        w;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_wait   <= 0;
        end else if (o_out_valid && i_out_ready) begin
            reports_seen++;
            if (report_queue.size() == 0) begin
                $error("output word for bin %0d with no input word pending",
                       o_out_word.bin_out);
                mismatches++;
            end else begin
                want = report_queue.pop_front();
                if (o_out_word.bin_out !== want.bin_out) begin
                    $error("bin_out: expected %0d, got %0d",
                           want.bin_out, o_out_word.bin_out);
                    mismatches++;
                end
                if (o_out_word.peak_magnitude !== want.peak_magnitude) begin
                    $error("peak_magnitude: expected %0d, got %0d",
                           want.peak_magnitude, o_out_word.peak_magnitude);
                    mismatches++;
                end
                if (o_out_word.level_dbm !== want.level_dbm) begin
                    $error("level_dbm: expected %0d, got %0d",
                           want.level_dbm, o_out_word.level_dbm);
                    mismatches++;
                end
            end
            w = draw_gap();
            recv_wait   <= w;
            i_out_ready <= (w == 0);
        end else if (recv_wait > 0) begin
            recv_wait   <= recv_wait - 1;
            i_out_ready <= (recv_wait == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_sample(logic [BIN_W-1:0] bin, logic [MAG_W-1:0] mag);
        sample_queue.push_back('{bin_index: bin, rssi_magnitude: mag});
    endtask

    // checked mid-cycle, once the driver's updates at the edge have landed
    task automatic settle();
        do @(negedge i_clk);
        while (sample_queue.size() != 0 || i_in_valid || report_queue.size() != 0);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_HOLD:     hold_len   = val;
            CFG_INTERVAL: decay_ival = val;
            CFG_AMOUNT:   decay_amt  = val[AMT_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic write_settings(logic [CNT_W-1:0] h, logic [CNT_W-1:0] iv,
                                  logic [AMT_W-1:0] a);
        write_reg(CFG_HOLD, h);
        write_reg(CFG_INTERVAL, iv);
        // upper bits of the amount word are don't-care
        write_reg(CFG_AMOUNT, {8'($urandom), a});
    endtask

    initial begin
        logic [BIN_W-1:0] pool [8];
        logic [BIN_W-1:0] b;
        logic [CNT_W-1:0] h;
        logic [CNT_W-1:0] iv;
        logic [AMT_W-1:0] a;
        int               pool_n;
        int               left;
        int               run;

        for (int k = 0; k < NUM_BINS; k++) begin
            peak_held[k]  = PEAK_MAX;
            hold_count[k] = '0;
        end
        hold_len     = 16'd2;
        decay_ival   = 16'd1;
        decay_amt    = 8'd2;
        calm         = 1'b0;
        mismatches   = 0;
        samples_sent = 0;
        reports_seen = 0;
        reg_writes   = 0;
        stall_cycles = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: extremes, equal-to-peak, then decay after the hold
        queue_sample(7'd0, 7'd0);
        queue_sample(7'd127, 7'd127);
        queue_sample(7'd127, 7'd0);
        repeat (5) queue_sample(7'd0, 7'd127);
        queue_sample(7'd0, 7'd6);
        queue_sample(7'd0, 7'd5);
        settle();

        // no hold, zero interval, largest step: peak clips at the top
        write_settings(16'd0, 16'd0, 8'd255);
        queue_sample(7'd11, 7'd3);
        queue_sample(7'd11, 7'd100);
        queue_sample(7'd11, 7'd127);
        settle();

        // zero step: decay fires but the peak stays put
        write_reg(CFG_AMOUNT, 16'd0);
        queue_sample(7'd10, 7'd0);
        repeat (3) queue_sample(7'd10, 7'd9);
        settle();

        // longest hold and interval
        write_settings(CNT_MAX, CNT_MAX, 8'd1);
        queue_sample(7'd20, 7'd10);
        repeat (2) queue_sample(7'd20, 7'd50);
        settle();

        for (int p = 0; p < 7; p++) begin
            case ($urandom_range(0, 5))
                0:       h = 16'd0;
                1:       h = CNT_MAX;
                default: h = 16'($urandom_range(0, 6));
            endcase
            case ($urandom_range(0, 5))
                0:       iv = 16'd0;
                1:       iv = 16'hFFFF;
                2:       iv = 16'd1;
                default: iv = 16'($urandom_range(1, 4));
            endcase
            case ($urandom_range(0, 5))
                0:       a = 8'd0;
                1:       a = 8'd255;
                2:       a = 8'd1;
                default: a = 8'($urandom_range(1, 40));
            endcase
            write_settings(h, iv, a);
            calm   = ($urandom_range(0, 3) == 0);
            pool_n = $urandom_range(1, 8);
            for (int k = 0; k < 8; k++) pool[k] = 7'($urandom);
            left = 200;
            while (left > 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    queue_sample(7'($urandom), 7'($urandom));
                    left--;
                end else begin
                    // strong sample, then a run of weaker ones to build the counter
                    if ($urandom_range(0, 4) == 0) b = 7'($urandom);
                    else b = pool[$urandom_range(0, pool_n - 1)];
                    queue_sample(b, 7'($urandom_range(0, 40)));
                    left--;
                    run = $urandom_range(1, 12);
                    while (run > 0 && left > 0) begin
                        if ($urandom_range(0, 7) == 0) queue_sample(b, 7'($urandom));
                        else queue_sample(b, 7'($urandom_range(41, 127)));
                        run--;
                        left--;
                    end
                end
            end
            settle();
        end

        repeat (40) @(posedge i_clk);
        $display("Run covered %0d input words and %0d output words over %0d register writes,",
                 samples_sent, reports_seen, reg_writes);
        $display("including edge settings and random sweeps with decay on busy bins.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
